// File: rtl/degree_run_length_encoder_unit_macros.svh
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef DEGREE_RUN_LENGTH_ENCODER_UNIT_MACROS_SVH
`define DEGREE_RUN_LENGTH_ENCODER_UNIT_MACROS_SVH

// same-cycle implication
`define DRLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/drle_pkg.sv
package drle_pkg;

  localparam int unsigned DegW = 30;
  localparam int unsigned LenW = 32;

  localparam logic [DegW-1:0] OneByteLim = DegW'(64);
  localparam logic [DegW-1:0] TwoByteLim = DegW'(16383);
  localparam logic [LenW-1:0] LenMax     = '1;

  localparam logic [7:0] OneByteTag = 8'h80;
  localparam logic [7:0] TwoByteTag = 8'hc0;

  typedef enum logic [1:0] {
    VC_ONE,
    VC_TWO,
    VC_FOUR
  } vclass_e;

  // one finished run waiting to be serialized
  typedef struct packed {
    logic [DegW-1:0] value;
    logic [LenW-1:0] length;
    vclass_e         vclass;
    logic            fin;
  } run_rec_t;

  // up to two runs leave the front per accepted word
  typedef struct packed {
    logic     wr0;
    logic     wr1;
    run_rec_t rec0;
    run_rec_t rec1;
  } run_push_t;

  function automatic vclass_e classify(input logic [DegW-1:0] v);
    vclass_e c;
    if (v < OneByteLim) begin
      c = VC_ONE;
    end else if (v < TwoByteLim) begin
      c = VC_TWO;
    end else begin
      c = VC_FOUR;
    end
    return c;
  endfunction

endpackage

// File: rtl/drle_front.sv
module drle_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [drle_pkg::DegW-1:0] degree_i,
  input  logic                   final_i,
  output drle_pkg::run_push_t    push_o
);

  logic [drle_pkg::DegW-1:0] value_q, value_d;
  logic [drle_pkg::LenW-1:0] length_q, length_d;
  logic                      open_q, open_d;

  logic                      emit_old;
  logic [drle_pkg::DegW-1:0] cur_value;
  logic [drle_pkg::LenW-1:0] cur_length;
  drle_pkg::run_rec_t        old_rec, fin_rec;

  always_comb begin
    emit_old   = 1'b0;
    cur_value  = value_q;
    cur_length = length_q;
    if (!open_q) begin
      cur_value  = degree_i;
      cur_length = drle_pkg::LenW'(1);
    end else if (degree_i == value_q) begin
      if (length_q != drle_pkg::LenMax) begin
        cur_length = length_q + 1'b1;
      end
    end else begin
      emit_old   = 1'b1;
      cur_value  = degree_i;
      cur_length = drle_pkg::LenW'(1);
    end

    old_rec.value  = value_q;
    old_rec.length = length_q;
    old_rec.vclass = drle_pkg::classify(value_q);
    old_rec.fin    = 1'b0;

    fin_rec.value  = cur_value;
    fin_rec.length = cur_length;
    fin_rec.vclass = drle_pkg::classify(cur_value);
    fin_rec.fin    = 1'b1;

    push_o.wr0  = accept_i && (emit_old || final_i);
    push_o.wr1  = accept_i && emit_old && final_i;
    push_o.rec0 = emit_old ? old_rec : fin_rec;
    push_o.rec1 = fin_rec;

    value_d  = value_q;
    length_d = length_q;
    open_d   = open_q;
    if (accept_i) begin
      if (final_i) begin
        // stream closes, next word starts fresh
        value_d  = '0;
        length_d = '0;
        open_d   = 1'b0;
      end else begin
        value_d  = cur_value;
        length_d = cur_length;
        open_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q  <= '0;
      length_q <= '0;
      open_q   <= 1'b0;
    end else begin
      value_q  <= value_d;
      length_q <= length_d;
      open_q   <= open_d;
    end
  end

endmodule

// File: rtl/drle_queue.sv
`include "degree_run_length_encoder_unit_macros.svh"

module drle_queue #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  drle_pkg::run_push_t push_i,
  output logic                room2_o,
  output logic                head_valid_o,
  output drle_pkg::run_rec_t  head_o,
  input  logic                pop_i
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(QDEPTH);
  localparam logic [CW-1:0] RoomC  = CW'(QDEPTH - 2);
  localparam logic [PW-1:0] LastPtr = PW'(QDEPTH - 1);

  drle_pkg::run_rec_t mem_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] wr_ptr_nx;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nx    = ptr_inc(wr_ptr_q);
    room2_o      = (count_q <= RoomC);
    head_valid_o = (count_q != '0);
    head_o       = mem_q[rd_ptr_q];

    wr_ptr_d = wr_ptr_q;
    if (push_i.wr1) begin
      wr_ptr_d = ptr_inc(wr_ptr_nx);
    end else if (push_i.wr0) begin
      wr_ptr_d = wr_ptr_nx;
    end
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CW'(push_i.wr0) + CW'(push_i.wr1) - CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.wr0) begin
      mem_q[wr_ptr_q] <= push_i.rec0;
    end
    if (push_i.wr1) begin
      mem_q[wr_ptr_nx] <= push_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `DRLE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DepthC, "queue count above depth")
  `DRLE_ASSERT_NOW(a_pair_order, push_i.wr1, push_i.wr0, "second write without first")
  `DRLE_ASSERT_NOW(a_no_empty_pop, pop_i, head_valid_o, "pop from empty queue")

endmodule

// File: rtl/drle_back.sv
`include "degree_run_length_encoder_unit_macros.svh"

module drle_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  drle_pkg::run_rec_t head_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,
  output logic               m_axis_tlast
);

  localparam logic [2:0] RemOne  = 3'd4;
  localparam logic [2:0] RemTwo  = 3'd5;
  localparam logic [2:0] RemFour = 3'd7;

  logic [63:0] seq_q, seq_d, load_seq;
  logic [2:0]  rem_q, rem_d, load_rem;
  logic        fin_q, fin_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;
  logic        slot_free;

  // bytes of a run, first byte in the top lane
  always_comb begin
    case (head_i.vclass)
      drle_pkg::VC_ONE: begin
        load_seq = {drle_pkg::OneByteTag | head_i.value[7:0], head_i.length, 24'h0};
        load_rem = RemOne;
      end
      drle_pkg::VC_TWO: begin
        load_seq = {drle_pkg::TwoByteTag | head_i.value[15:8], head_i.value[7:0],
                    head_i.length, 16'h0};
        load_rem = RemTwo;
      end
      default: begin
        load_seq = {2'b00, head_i.value, head_i.length};
        load_rem = RemFour;
      end
    endcase
  end

  always_comb begin
    slot_free   = !out_valid_q || m_axis_tready;
    pop_o       = 1'b0;
    seq_d       = seq_q;
    rem_d       = rem_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (slot_free) begin
      if (rem_q != 3'd0) begin
        out_valid_d = 1'b1;
        out_byte_d  = seq_q[63:56];
        out_last_d  = fin_q && (rem_q == 3'd1);
        seq_d       = {seq_q[55:0], 8'h0};
        rem_d       = rem_q - 1'b1;
      end else if (head_valid_i) begin
        pop_o       = 1'b1;
        out_valid_d = 1'b1;
        out_byte_d  = load_seq[63:56];
        out_last_d  = 1'b0;
        seq_d       = {load_seq[55:0], 8'h0};
        rem_d       = load_rem;
        fin_d       = head_i.fin;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q      <= seq_d;
    fin_q      <= fin_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  `DRLE_ASSERT_NOW(a_rem_has_byte, rem_q != 3'd0, out_valid_q, "pending bytes with empty output")
  `DRLE_ASSERT_NOW(a_last_ends_run, out_valid_q && out_last_q, rem_q == 3'd0,
                   "last byte before run end")
  `DRLE_ASSERT_NEXT(a_pop_loads, pop_o, rem_q >= RemOne, "pop without loading a run")

endmodule

// File: rtl/degree_run_length_encoder_unit.sv
// channel   dir  tdata                         tuser  tlast
// s_axis    in   [29:0] degree, [31:30] zero   -      final_vertex
// m_axis    out  [7:0] out_byte                -      last_byte
//
// the front takes one word per cycle while
// the run queue has room for two runs
// each finished run leaves as 5, 6 or 8 bytes at one byte per cycle while
// m_axis_tready is high, so a word that closes runs yields 5 to 16 bytes
// rst_ni is asynchronous; afterwards no run is open and the queue is empty
// output stalls fill the queue and then drop s_axis_tready
module degree_run_length_encoder_unit #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [29:0] degree, [31:30] zero fill
  input  logic        s_axis_tlast,   // final_vertex
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast    // last_byte
);

  drle_pkg::run_push_t push;
  drle_pkg::run_rec_t  head;
  logic                room2, head_valid, pop, accept;

  assign s_axis_tready = room2;
  assign accept        = s_axis_tvalid && room2;

  drle_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .degree_i (s_axis_tdata[drle_pkg::DegW-1:0]),
    .final_i  (s_axis_tlast),
    .push_o   (push)
  );

  drle_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .room2_o      (room2),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  drle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: verif/tb_degree_run_length_encoder_unit.sv
`timescale 1ns / 1ps

module tb_degree_run_length_encoder_unit;

  localparam int unsigned DEG_W       = 30;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned ITEM_TARGET = 280;
  localparam int unsigned CALM_TAIL   = 40;
  localparam int unsigned DRAIN_CYC   = 40;
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic [DEG_W-1:0] DEG_MAX   = '1;
  localparam logic [LEN_W-1:0] LEN_SAT   = '1;
  localparam logic [DEG_W-1:0] ONE_LIMIT = 30'd64;
  localparam logic [DEG_W-1:0] TWO_LIMIT = 30'd16383;
  localparam logic [7:0]       ONE_TAG   = 8'h80;
  localparam logic [7:0]       TWO_TAG   = 8'hc0;

  typedef struct packed {
    logic [DEG_W-1:0] deg;
    logic             fin;
  } vertex_t;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } code_byte_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  vertex_t     vertex_q[$];
  code_byte_t  code_q[$];

  // encoder state as seen from outside
  logic [DEG_W-1:0] run_val = '0;
  logic [LEN_W-1:0] run_len = '0;
  logic             run_on  = 1'b0;

  int unsigned cyc       = 0;
  int unsigned src_gap   = 0;
  int unsigned snk_gap   = 0;
  int unsigned err_cnt   = 0;
  int unsigned bytes_out = 0;

  degree_run_length_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic push_code(input logic [7:0] val, input logic last);
    code_byte_t b;
    b.val  = val;
    b.last = last;
    code_q.insert(code_q.size(), b);
  endtask

  // value in its short form, then the length as four big-endian bytes
  task automatic push_run(input logic [DEG_W-1:0] v, input logic [LEN_W-1:0] n,
                          input logic fin);
    logic [31:0] wide;
    wide = {2'b00, v};
    if (v < ONE_LIMIT) begin
      push_code(ONE_TAG | wide[7:0], 1'b0);
    end else if (v < TWO_LIMIT) begin
      push_code(TWO_TAG | wide[15:8], 1'b0);
      push_code(wide[7:0], 1'b0);
    end else begin
      push_code(wide[31:24], 1'b0);
      push_code(wide[23:16], 1'b0);
      push_code(wide[15:8], 1'b0);
      push_code(wide[7:0], 1'b0);
    end
    push_code(n[31:24], 1'b0);
    push_code(n[23:16], 1'b0);
    push_code(n[15:8], 1'b0);
    push_code(n[7:0], fin);
  endtask

  task automatic encode_vertex(input vertex_t vx);
    if (!run_on) begin
      run_val = vx.deg;
      run_len = 1;
      run_on  = 1'b1;
    end else if (vx.deg == run_val) begin
      if (run_len != LEN_SAT) run_len = run_len + 1;
    end else begin
      push_run(run_val, run_len, 1'b0);
      run_val = vx.deg;
      run_len = 1;
    end
    if (vx.fin) begin
      push_run(run_val, run_len, 1'b1);
      run_val = '0;
      run_len = '0;
      run_on  = 1'b0;
    end
  endtask

  task automatic add_vertex(input logic [DEG_W-1:0] deg, input logic fin);
    vertex_t vx;
    vx.deg = deg;
    vx.fin = fin;
    vertex_q.insert(vertex_q.size(), vx);
  endtask

  function automatic logic [DEG_W-1:0] pick_degree();
    logic [DEG_W-1:0] d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: d = DEG_W'($urandom_range(0, 63));
      4, 5, 6:    d = DEG_W'($urandom_range(64, 16382));
      7, 8:       d = DEG_W'($urandom_range(16383, 32'h3fffffff));
      default: begin
        case ($urandom_range(0, 5))
          0:       d = '0;
          1:       d = ONE_LIMIT - 1'b1;
          2:       d = ONE_LIMIT;
          3:       d = TWO_LIMIT - 1'b1;
          4:       d = TWO_LIMIT;
          default: d = DEG_MAX;
        endcase
      end
    endcase
    return d;
  endfunction

  // source side: present the head of the pending queue, predict on acceptance
  always @(posedge clk_i) begin
    logic holding;
    if (rst_ni) begin
      holding = s_axis_tvalid && !s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        encode_vertex(vertex_q[0]);
        void'(vertex_q.pop_front());
      end
      if (src_gap > 0) begin
        src_gap--;
      end else if (!holding && vertex_q.size() > CALM_TAIL && !cyc[6] &&
                   $urandom_range(0, 4) == 0) begin
        src_gap = $urandom_range(1, 6);
      end
      if (src_gap == 0 && vertex_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, vertex_q[0].deg};
        s_axis_tlast  <= vertex_q[0].fin;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink side: check each accepted word against the oldest predicted byte
  always @(posedge clk_i) begin
    code_byte_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (code_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %02h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          err_cnt++;
        end else begin
          want = code_q.pop_front();
          if (m_axis_tdata !== want.val) begin
            $display("%0t: byte %0d out_byte expected %02h, got %02h",
                     $time, bytes_out, want.val, m_axis_tdata);
            err_cnt++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: byte %0d last_byte expected %b, got %b",
                     $time, bytes_out, want.last, m_axis_tlast);
            err_cnt++;
          end
        end
        bytes_out++;
      end
      if (snk_gap > 0) begin
        snk_gap--;
      end else if (vertex_q.size() > CALM_TAIL && cyc[7:6] != 2'b11 &&
                   $urandom_range(0, 3) == 0) begin
        snk_gap = $urandom_range(1, 6);
      end
      m_axis_tready <= (snk_gap == 0);
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned run_items;
    logic [DEG_W-1:0] deg;

    // single-vertex streams across every value form and its edges
    add_vertex('0, 1'b1);
    add_vertex(ONE_LIMIT - 1'b1, 1'b1);
    add_vertex(ONE_LIMIT, 1'b1);
    add_vertex(TWO_LIMIT - 1'b1, 1'b1);
    add_vertex(TWO_LIMIT, 1'b1);
    add_vertex(DEG_MAX, 1'b1);
    // run of three closed by a change that is also final
    add_vertex(30'd5, 1'b0);
    add_vertex(30'd5, 1'b0);
    add_vertex(30'd5, 1'b0);
    add_vertex(30'd9, 1'b1);
    // two four-byte runs in one word, the longest burst
    add_vertex(30'd20000, 1'b0);
    add_vertex(30'd20000, 1'b0);
    add_vertex(DEG_MAX, 1'b1);
    // changes between forms inside one stream
    add_vertex(30'd100, 1'b0);
    add_vertex(30'd100, 1'b0);
    add_vertex(TWO_LIMIT - 1'b1, 1'b0);
    add_vertex(30'd63, 1'b0);
    add_vertex(30'd63, 1'b1);
    // alternating bit patterns
    add_vertex(30'h2aaaaaaa, 1'b0);
    add_vertex(30'h15555555, 1'b0);
    add_vertex(30'h15555555, 1'b1);

    deg = '0;
    while (vertex_q.size() < ITEM_TARGET) begin
      run_items = $urandom_range(1, 30);
      for (int i = 0; i < run_items; i++) begin
        if (i == 0 || $urandom_range(0, 1) == 0) deg = pick_degree();
        add_vertex(deg, i == run_items - 1);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (vertex_q.size() != 0 || code_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
